// ===== hw/rtl/wsp_pkg.sv =====
// Shared types, constants and helpers of the wheel speed PID core.
`default_nettype none

package wsp_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;

    // Register reset values.
    localparam logic signed [31:0] PROP_GAIN_RST  = 32'sd655360;
    localparam logic signed [31:0] INTEG_GAIN_RST = 32'sd196608;
    localparam logic signed [31:0] DERIV_GAIN_RST = 32'sd655360;
    localparam logic [15:0]        OUT_LIMIT_RST  = 16'd1000;
    localparam logic [15:0]        SPEED_PC_RST   = 16'd2743;
    localparam logic               FWD_LEVEL_RST  = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_OUT_LIMIT  = 3'd3,
        CFG_SPEED_PC   = 3'd4,
        CFG_FWD_LEVEL  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] pulse_count;
        logic                  dir_level;
        logic signed [31:0]    target_speed;
    } sample_t;

    typedef struct packed {
        logic [15:0]        duty;
        logic               backward;
        logic signed [31:0] measured_speed;
    } result_t;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain;
        logic [15:0]        out_limit;
        logic [15:0]        speed_per_count;
        logic               forward_level;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        MUL_PROP  = 2'd0,
        MUL_INTEG = 2'd1,
        MUL_DERIV = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;       // capture the sample and form the pulse product
        logic     calc_err;   // measured speed and error
        logic     calc_diff;  // difference terms, clear the increment
        logic     mul_en;     // run the shared multiplier
        mul_sel_t mul_sel;
        logic     add_term;   // add the registered product to the increment
        logic     commit;     // update history, output and result
    } cmd_t;

    typedef struct packed {
        logic out_blocked;    // result slot holds an item that is not taken
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x > 35'(S32_MAX)) begin
            r = S32_MAX;
        end else if (x < 35'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsp_cfg.sv =====
// Configuration register file of the wheel speed PID core.
`default_nettype none

module wsp_cfg
    import wsp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]             cfg_data,
    output cfg_regs_t                    regs
);

    cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            regs_reg.prop_gain       <= PROP_GAIN_RST;
            regs_reg.integ_gain      <= INTEG_GAIN_RST;
            regs_reg.deriv_gain      <= DERIV_GAIN_RST;
            regs_reg.out_limit       <= OUT_LIMIT_RST;
            regs_reg.speed_per_count <= SPEED_PC_RST;
            regs_reg.forward_level   <= FWD_LEVEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            // Indexes past the last register are dropped.
            case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:  regs_reg.prop_gain       <= $signed(cfg_data);
                CFG_INTEG_GAIN: regs_reg.integ_gain      <= $signed(cfg_data);
                CFG_DERIV_GAIN: regs_reg.deriv_gain      <= $signed(cfg_data);
                CFG_OUT_LIMIT:  regs_reg.out_limit       <= cfg_data[15:0];
                CFG_SPEED_PC:   regs_reg.speed_per_count <= cfg_data[15:0];
                CFG_FWD_LEVEL:  regs_reg.forward_level   <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wsp_ctrl.sv =====
// Step sequencer of the wheel speed PID core.
`default_nettype none

module wsp_ctrl
    import wsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic sample_valid,
    output logic      sample_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ERR   = 7'b0000010,
        S_DIFF  = 7'b0000100,
        S_MUL_P = 7'b0001000,
        S_MUL_I = 7'b0010000,
        S_MUL_D = 7'b0100000,
        S_ACC   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   commit_ok;

    assign sample_stall = (state_reg != S_IDLE);
    assign commit_ok    = !sts.out_blocked;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PROP;
        case (state_reg)
            S_IDLE: begin
                if (sample_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                cmd.calc_err = 1'b1;
                state_next   = S_DIFF;
            end
            S_DIFF: begin
                cmd.calc_diff = 1'b1;
                state_next    = S_MUL_P;
            end
            S_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = S_MUL_I;
            end
            S_MUL_I: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_INTEG;
                cmd.add_term = 1'b1;
                state_next   = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DERIV;
                cmd.add_term = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC: begin
                // The last product joins the sum directly here; the commit waits
                // until the result slot is free.
                if (commit_ok) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_to_err: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (state_reg == S_ERR))
        else $error("accepted item did not start the error step");

    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && !sts.out_blocked) |=> (state_reg == S_IDLE))
        else $error("free result slot did not end the item");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && sts.out_blocked) |=> (state_reg == S_ACC))
        else $error("item left the final step while the result slot was full");

endmodule

`default_nettype wire

// ===== hw/rtl/wsp_dp.sv =====
// Datapath of the wheel speed PID core: speed, error history, shared multiplier.
`default_nettype none

module wsp_dp
    import wsp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sample_t   sample,
    input  wire cfg_regs_t regs,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output logic           result_valid,
    input  wire logic      result_stall,
    output result_t        result
);

    localparam int MAG_BITS = COUNT_BITS + 16;
    localparam int ACC_BITS = 48;
    localparam int SUM_BITS = 64;

    // Item operands, no reset needed.
    logic [MAG_BITS-1:0]       mag_reg;
    logic                      dir_reg;
    logic signed [31:0]        target_reg;
    logic signed [31:0]        speed_reg;
    logic signed [31:0]        err_reg;
    logic signed [31:0]        d1_reg;
    logic signed [31:0]        d2_reg;
    logic signed [63:0]        prod_reg;
    logic signed [SUM_BITS-1:0] inc_reg;
    logic signed [31:0]        out_speed_reg;

    // Controller history, reset to zero.
    logic signed [31:0]         e1_reg;
    logic signed [31:0]         e2_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic                       out_valid_reg;

    logic signed [31:0]         speed_now;
    logic [31:0]                mag_neg;
    logic signed [32:0]         err_wide;
    logic signed [34:0]         d1_wide;
    logic signed [34:0]         d2_wide;
    logic signed [31:0]         mul_a;
    logic signed [31:0]         mul_b;
    logic signed [SUM_BITS-1:0] term;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] limit;
    logic signed [SUM_BITS-1:0] acc_clamped;
    logic [ACC_BITS-1:0]        acc_mag;
    logic [15:0]                duty;

    assign sts.out_blocked = out_valid_reg && result_stall;

    // Signed speed from the pulse product; a reverse product of exactly 2^31
    // still fits as the most negative value.
    assign mag_neg = 32'(~mag_reg) + 32'd1;
    always_comb begin
        if (dir_reg == regs.forward_level) begin
            speed_now = mag_reg[31] ? S32_MAX : $signed(mag_reg[31:0]);
        end else if (mag_reg > MAG_BITS'(33'h0_8000_0000)) begin
            speed_now = S32_MIN;
        end else begin
            speed_now = $signed(mag_neg);
        end
    end

    assign err_wide = 33'(target_reg) - 33'(speed_now);
    assign d1_wide  = 35'(err_reg) - 35'(e1_reg);
    assign d2_wide  = 35'(err_reg) - (35'(e1_reg) <<< 1) + 35'(e2_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_PROP: begin
                mul_a = regs.prop_gain;
                mul_b = d1_reg;
            end
            MUL_INTEG: begin
                mul_a = regs.integ_gain;
                mul_b = err_reg;
            end
            MUL_DERIV: begin
                mul_a = regs.deriv_gain;
                mul_b = d2_reg;
            end
            default: begin
                mul_a = regs.prop_gain;
                mul_b = d1_reg;
            end
        endcase
    end

    // Arithmetic shift rounds each term toward minus infinity.
    assign term = prod_reg >>> FRAC_BITS;

    assign sum   = SUM_BITS'(acc_reg) + inc_reg + term;
    assign limit = $signed(SUM_BITS'(regs.out_limit) << FRAC_BITS);
    always_comb begin
        if (sum > limit) begin
            acc_clamped = limit;
        end else if (sum < -limit) begin
            acc_clamped = -limit;
        end else begin
            acc_clamped = sum;
        end
    end

    assign acc_mag = acc_reg[ACC_BITS-1] ? ACC_BITS'(-acc_reg) : ACC_BITS'(acc_reg);
    assign duty    = 16'(acc_mag >> FRAC_BITS);

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            mag_reg    <= MAG_BITS'(sample.pulse_count) * MAG_BITS'(regs.speed_per_count);
            dir_reg    <= sample.dir_level;
            target_reg <= sample.target_speed;
        end
        if (cmd.calc_err) begin
            speed_reg <= speed_now;
            err_reg   <= sat32(35'(err_wide));
        end
        if (cmd.calc_diff) begin
            d1_reg  <= sat32(d1_wide);
            d2_reg  <= sat32(d2_wide);
            inc_reg <= '0;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.add_term) begin
            inc_reg <= inc_reg + term;
        end
        if (cmd.commit) begin
            out_speed_reg <= speed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            e1_reg        <= '0;
            e2_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                e2_reg        <= e1_reg;
                e1_reg        <= err_reg;
                acc_reg       <= acc_clamped[ACC_BITS-1:0];
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && !result_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid          = out_valid_reg;
    assign result.duty           = duty;
    assign result.backward       = acc_reg[ACC_BITS-1] && (duty != 16'd0);
    assign result.measured_speed = out_speed_reg;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && result_stall))
        else $error("commit overwrote a result that was not taken");

    a_stalled_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("stalled result was dropped");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("committed item did not appear as a result");

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_speed_incremental_pid_core.sv =====
// Top level of the wheel speed incremental PID core.
//
// Channel  Handshake             Payload           Role
// sample   sample_valid/_stall   sample_t          pulse count, direction, target in
// result   result_valid/_stall   result_t          duty, backward flag, speed out
// cfg      cfg_valid/cfg_ready   cfg_index/data    register writes, always ready
//
// An item runs through these steps: pulse product on accept, then error, differences, three
// passes through the shared 32x32 multiplier and a final accumulate and clamp.
// A new item is taken only once the previous one has committed its result.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its final step waits for the slot to drain.
// Reset clears the error history and the stored output and restores register defaults.
`default_nettype none

module wheel_speed_incremental_pid_core
    import wsp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    sample_valid,
    output logic                         sample_stall,
    input  wire sample_t                 sample,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output result_t                      result,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]             cfg_data
);

    cfg_regs_t regs;
    cmd_t      cmd;
    sts_t      sts;

    wsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    wsp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    wsp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .regs         (regs),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== test/wheel_speed_incremental_pid_core_tb.sv =====
// Self-checking testbench of the wheel speed incremental PID core.
module wheel_speed_incremental_pid_core_tb
    import wsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_W          = 16;
    localparam int SETTLE_CYCLES   = 12;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 122;
    localparam int HOLD_AT         = 150;
    localparam int HOLD_CYCLES     = 300;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;

    typedef struct {
        bit                      is_write;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic [31:0]             reg_val;
        sample_t                 smp;
        bit                      typed;
        result_t                 want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    sample_valid;
    logic                    sample_stall;
    sample_t                 sample;
    logic                    result_valid;
    logic                    result_stall;
    result_t                 result;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0]             cfg_data;

    cfg_regs_t   shadow_regs;
    longint      err_last;
    longint      err_prev;
    longint      out_acc;
    result_t     results_due[$];
    plan_row_t   plan[$];
    int          mismatches;
    int          idle_cycles;
    bit          send_calm;

    wheel_speed_incremental_pid_core #(
        .FRAC_BITS(FRAC_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample      (sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint clamp_s32(input longint x);
        if (x > SPEED_MAX)
        begin
            return SPEED_MAX;
        end
        if (x < SPEED_MIN)
        begin
            return SPEED_MIN;
        end
        return x;
    endfunction

    function automatic void reset_controller();
        shadow_regs.prop_gain       = PROP_GAIN_RST;
        shadow_regs.integ_gain      = INTEG_GAIN_RST;
        shadow_regs.deriv_gain      = DERIV_GAIN_RST;
        shadow_regs.out_limit       = OUT_LIMIT_RST;
        shadow_regs.speed_per_count = SPEED_PC_RST;
        shadow_regs.forward_level   = FWD_LEVEL_RST;
        err_last = 0;
        err_prev = 0;
        out_acc  = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [31:0] val);
        case (idx)
            CFG_PROP_GAIN:  shadow_regs.prop_gain       = val;
            CFG_INTEG_GAIN: shadow_regs.integ_gain      = val;
            CFG_DERIV_GAIN: shadow_regs.deriv_gain      = val;
            CFG_OUT_LIMIT:  shadow_regs.out_limit       = val[15:0];
            CFG_SPEED_PC:   shadow_regs.speed_per_count = val[15:0];
            CFG_FWD_LEVEL:  shadow_regs.forward_level   = val[0];
            default: ;
        endcase
    endfunction

    // One control tick: measured speed, error history, clamped output and duty.
    function automatic result_t predict_wheel_step(input sample_t s);
        longint  mag;
        longint  spd;
        longint  err;
        longint  d1;
        longint  d2;
        longint  inc;
        longint  lim;
        longint  acc;
        longint  amag;
        result_t r;
        mag = longint'(s.pulse_count) * longint'(shadow_regs.speed_per_count);
        if (s.dir_level == shadow_regs.forward_level)
        begin
            spd = (mag > SPEED_MAX) ? SPEED_MAX : mag;
        end
        else
        begin
            spd = (mag > -SPEED_MIN) ? SPEED_MIN : -mag;
        end
        err = clamp_s32(longint'($signed(s.target_speed)) - spd);
        d1  = clamp_s32(err - err_last);
        d2  = clamp_s32(err - 2 * err_last + err_prev);
        inc = ((longint'($signed(shadow_regs.prop_gain)) * d1) >>> FRAC_W)
            + ((longint'($signed(shadow_regs.integ_gain)) * err) >>> FRAC_W)
            + ((longint'($signed(shadow_regs.deriv_gain)) * d2) >>> FRAC_W);
        err_prev = err_last;
        err_last = err;
        lim = longint'(shadow_regs.out_limit) << FRAC_W;
        acc = out_acc + inc;
        if (acc > lim)
        begin
            acc = lim;
        end
        else if (acc < -lim)
        begin
            acc = -lim;
        end
        out_acc = acc;
        amag = (acc < 0) ? -acc : acc;
        r.duty           = amag[FRAC_W +: 16];
        r.backward       = (acc < 0) && ((amag >> FRAC_W) != 0);
        r.measured_speed = spd[31:0];
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic [15:0] pulses, input logic dir,
                                           input logic [31:0] target);
        plan_row_t row;
        row = '{default: '0};
        row.smp.pulse_count  = pulses;
        row.smp.dir_level    = dir;
        row.smp.target_speed = target;
        return row;
    endfunction

    function automatic plan_row_t known_row(input logic [15:0] pulses, input logic dir,
                                            input logic [31:0] target,
                                            input logic [15:0] duty, input logic back,
                                            input logic [31:0] speed);
        plan_row_t row;
        row = item_row(pulses, dir, target);
        row.typed               = 1'b1;
        row.want.duty           = duty;
        row.want.backward       = back;
        row.want.measured_speed = speed;
        return row;
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_IDX_BITS-1:0] idx,
                                            input logic [31:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        return row;
    endfunction

    // Mostly everyday values, now and then an extreme or raw random bits.
    function automatic logic [31:0] pick_reg_value(input cfg_idx_t idx);
        int          draw;
        logic [31:0] v;
        draw = $urandom_range(0, 9);
        if (draw == 2)
        begin
            return $urandom;
        end
        case (idx)
            CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_DERIV_GAIN:
            begin
                v = $urandom_range(0, 20 << FRAC_W);
                if ($urandom_range(0, 7) == 0)
                begin
                    v = -v;
                end
                if (draw == 0)
                begin
                    v = S32_MIN;
                end
                else if (draw == 1)
                begin
                    v = S32_MAX;
                end
            end
            CFG_OUT_LIMIT:
            begin
                v = (draw == 0) ? 32'd0 : (draw == 1) ? 32'hFFFF : $urandom_range(50, 3000);
            end
            CFG_SPEED_PC:
            begin
                v = (draw == 0) ? 32'd0 : (draw == 1) ? 32'hFFFF : $urandom_range(500, 6000);
            end
            default:
            begin
                v = (draw == 0) ? 32'd0 : (draw == 1) ? 32'd1 : $urandom_range(0, 1);
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic offer_sample(input sample_t s, input bit typed, input result_t want);
        int      gap;
        result_t guess;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (sample_stall);
        guess = predict_wheel_step(s);
        results_due.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only once every item has come out and the pipe is empty.
    task automatic settle();
        sample_valid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold that fills the block.
    initial
    begin
        int gap;
        int got;
        bit calm;
        got  = 0;
        calm = 1'b0;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (got % 40 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if (got == HOLD_AT)
            begin
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, 13);
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            got++;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("result with no item pending", longint'(result.duty), 0);
            end
            else
            begin
                want = results_due.pop_front();
                if (result.duty !== want.duty)
                begin
                    report_mismatch("duty", longint'(result.duty), longint'(want.duty));
                end
                if (result.backward !== want.backward)
                begin
                    report_mismatch("backward", longint'(result.backward),
                                    longint'(want.backward));
                end
                if (result.measured_speed !== want.measured_speed)
                begin
                    report_mismatch("measured_speed", longint'($signed(result.measured_speed)),
                                    longint'($signed(want.measured_speed)));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_idx_t    all_regs[6];
        sample_t     s;
        result_t     none;
        logic [31:0] tgt;
        bit          was_item;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PROP_GAIN;
        cfg_data     = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        send_calm    = 1'b0;
        none         = '0;
        tgt          = '0;
        all_regs     = '{CFG_PROP_GAIN, CFG_INTEG_GAIN, CFG_DERIV_GAIN,
                         CFG_OUT_LIMIT, CFG_SPEED_PC, CFG_FWD_LEVEL};
        reset_controller();

        // Right after reset, then the error extremes drive the output into both limits.
        plan.push_back(known_row(16'd0, 1'b1, 32'd0, 16'd0, 1'b0, 32'd0));
        plan.push_back(known_row(16'd0, 1'b0, S32_MAX, 16'd1000, 1'b0, 32'd0));
        plan.push_back(known_row(16'd0, 1'b1, S32_MIN, 16'd1000, 1'b1, 32'd0));
        plan.push_back(item_row(16'hFFFF, 1'b1, 32'd0));
        plan.push_back(item_row(16'hFFFF, 1'b0, 32'd0));
        plan.push_back(item_row(16'd1, 1'b1, 32'd2743));
        // Largest scale and inverted polarity: measured speed saturates both ways.
        plan.push_back(write_row(CFG_SPEED_PC, 32'h0000_FFFF));
        plan.push_back(write_row(CFG_FWD_LEVEL, 32'd0));
        plan.push_back(write_row(CFG_OUT_LIMIT, 32'h0000_FFFF));
        plan.push_back(item_row(16'hFFFF, 1'b0, S32_MIN));
        plan.push_back(item_row(16'hFFFF, 1'b1, S32_MAX));
        plan.push_back(item_row(16'h8000, 1'b1, 32'd0));
        plan.push_back(write_row(CFG_PROP_GAIN, S32_MIN));
        plan.push_back(write_row(CFG_INTEG_GAIN, S32_MAX));
        plan.push_back(write_row(CFG_DERIV_GAIN, S32_MIN));
        plan.push_back(item_row(16'd0, 1'b0, 32'd12345));
        plan.push_back(item_row(16'd0, 1'b0, -32'sd7));
        // A zero limit pins the output; two quiet ticks then clear the error history.
        plan.push_back(write_row(CFG_PROP_GAIN, S32_MAX));
        plan.push_back(write_row(CFG_INTEG_GAIN, S32_MIN));
        plan.push_back(write_row(CFG_DERIV_GAIN, S32_MAX));
        plan.push_back(write_row(CFG_OUT_LIMIT, 32'd0));
        plan.push_back(item_row(16'd100, 1'b1, 32'd0));
        plan.push_back(item_row(16'd0, 1'b1, 32'd0));
        plan.push_back(item_row(16'd0, 1'b1, 32'd0));
        // Tiny integral gain leaves the output just below zero: duty 0, not backward.
        plan.push_back(write_row(CFG_PROP_GAIN, 32'd0));
        plan.push_back(write_row(CFG_INTEG_GAIN, 32'd1));
        plan.push_back(write_row(CFG_DERIV_GAIN, 32'd0));
        plan.push_back(write_row(CFG_OUT_LIMIT, 32'hABCD_03E8));
        plan.push_back(write_row(CFG_SPARE_LO, 32'hFFFF_FFFF));
        plan.push_back(write_row(CFG_SPARE_HI, 32'h0000_0000));
        plan.push_back(write_row(CFG_FWD_LEVEL, 32'hFFFF_FFFE));
        plan.push_back(item_row(16'd0, 1'b1, -32'sd1));
        plan.push_back(item_row(16'd0, 1'b0, -32'sd65536));
        plan.push_back(item_row(16'd0, 1'b1, 32'h0001_0000));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        was_item = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (was_item)
                begin
                    settle();
                end
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                was_item = 1'b0;
            end
            else
            begin
                offer_sample(plan[i].smp, plan[i].typed, plan[i].want);
                was_item = 1'b1;
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            foreach (all_regs[k])
            begin
                write_reg(all_regs[k], pick_reg_value(all_regs[k]));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
            end
            send_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // The setpoint holds for a few ticks, as it does in a real loop.
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 7))
                        0:       tgt = $urandom;
                        1:       tgt = '0;
                        default: tgt = $urandom_range(0, 60 << FRAC_W) - (30 << FRAC_W);
                    endcase
                end
                s.pulse_count  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                              : 16'($urandom_range(0, 3000));
                s.dir_level    = 1'($urandom_range(0, 1));
                s.target_speed = tgt;
                offer_sample(s, 1'b0, none);
            end
        end

        settle();
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
